@@ rtl/rcr_pkg.sv @@
package rcr_pkg;

  localparam int DEF_MAX_SIDE  = 256;
  localparam int DEF_FRAC_BITS = 8;

  localparam int COORD_W    = 24;
  localparam int DATA_W     = 8;
  localparam int CFG_SIDE_W = 9;
  localparam int BG_W       = 7;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [7:0]      CHAR_OUTLINE = 8'h72;
  localparam logic [7:0]      CHAR_FILLED  = 8'h52;
  localparam logic [7:0]      INK_MIN      = 8'd32;
  localparam logic [7:0]      INK_MAX      = 8'd126;
  localparam logic [BG_W-1:0] BG_RESET     = 7'd32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_CANVAS_W  = 2'd0,
    REG_CANVAS_H  = 2'd1,
    REG_BG_CHAR   = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ
  } state_e;

endpackage

@@ rtl/rcr_canvas_ram.sv @@
module rcr_canvas_ram #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rect_canvas_rasterizer.sv @@
// Channel   | Signals                                        | Handshake
// ----------+------------------------------------------------+-------------------------------
// request   | command_i, shape_code_i, rect_*_i, ink_char_i,  | taken when start && !busy
//           | pixel_col_i, pixel_row_i                       |
// result    | status_o, pixel_char_o                         | done_o, one cycle, no stall
// config    | psel, penable, pwrite, paddr, pwdata, prdata   | APB, pready tied high
//
// A clear or accepted draw walks the canvas in use at one pixel per cycle through the single
// memory write port, and its result is registered when the last pixel is visited. A read goes
// through the registered memory read port and then the result register. Rejected draws, empty
// walks, reads outside the canvas and the unused command answer in the cycle after the request.
// Reset clears control state and registers but not the canvas; it holds stale data until the
// first clear. The receiver cannot stall; results are presented for exactly one cycle.
module rect_canvas_rasterizer #(
  parameter int MAX_SIDE  = rcr_pkg::DEF_MAX_SIDE,
  parameter int FRAC_BITS = rcr_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command_i,
  input  logic [7:0]                         shape_code_i,
  input  logic signed [rcr_pkg::COORD_W-1:0] rect_left_i,
  input  logic signed [rcr_pkg::COORD_W-1:0] rect_top_i,
  input  logic signed [rcr_pkg::COORD_W-1:0] rect_width_i,
  input  logic signed [rcr_pkg::COORD_W-1:0] rect_height_i,
  input  logic [7:0]                         ink_char_i,
  input  logic [7:0]                         pixel_col_i,
  input  logic [7:0]                         pixel_row_i,
  output logic                               done_o,
  output logic                               status_o,
  output logic [rcr_pkg::DATA_W-1:0]         pixel_char_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rcr_pkg::APB_AW-1:0]         paddr,
  input  logic [rcr_pkg::APB_DW-1:0]         pwdata,
  output logic [rcr_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import rcr_pkg::*;

  localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int UW     = (CNT_W > CFG_SIDE_W) ? CNT_W : CFG_SIDE_W;
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = ((COORD_W + 2) > (IDX_W + FRAC_BITS + 1)) ?
                          (COORD_W + 2) : (IDX_W + FRAC_BITS + 1);
  localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  logic [CFG_SIDE_W-1:0] cfg_w_q, cfg_h_q;
  logic [BG_W-1:0]       bg_q;

  state_e state_q, state_d;
  logic [IDX_W-1:0] col_q, col_d, row_q, row_d;
  logic done_q, done_d, status_q, status_d;
  logic [DATA_W-1:0] pix_q, pix_d;

  logic signed [CW-1:0] left_q, right_q, top_q, bot_q;
  logic signed [CW-1:0] left1_q, right1_q, top1_q, bot1_q;
  logic                 filled_q, is_clear_q;
  logic [DATA_W-1:0]    ink_q;

  logic [CNT_W-1:0] w_used, h_used;
  logic             accept, cfg_we, draw_ok, nonempty, rd_hit;
  logic             last_col, last_row, in_rect, edge_hit, paint;
  logic signed [CW-1:0] px, py;
  logic signed [CW-1:0] right_in, bot_in;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= '0;
      cfg_h_q <= '0;
      bg_q    <= BG_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_CANVAS_W: cfg_w_q <= pwdata[CFG_SIDE_W-1:0];
        REG_CANVAS_H: cfg_h_q <= pwdata[CFG_SIDE_W-1:0];
        REG_BG_CHAR:  bg_q    <= pwdata[BG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CANVAS_W: prdata = APB_DW'(cfg_w_q);
      REG_CANVAS_H: prdata = APB_DW'(cfg_h_q);
      REG_BG_CHAR:  prdata = APB_DW'(bg_q);
      default:      prdata = '0;
    endcase
  end

  assign w_used = (UW'(cfg_w_q) > UW'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(cfg_w_q);
  assign h_used = (UW'(cfg_h_q) > UW'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(cfg_h_q);

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign nonempty = (w_used != '0) && (h_used != '0);
  assign draw_ok  = ((shape_code_i == CHAR_OUTLINE) || (shape_code_i == CHAR_FILLED)) &&
                    !rect_width_i[COORD_W-1] && (rect_width_i != '0) &&
                    !rect_height_i[COORD_W-1] && (rect_height_i != '0) &&
                    (ink_char_i >= INK_MIN) && (ink_char_i <= INK_MAX);
  assign rd_hit   = (UW'(pixel_col_i) < UW'(w_used)) && (UW'(pixel_row_i) < UW'(h_used));

  assign right_in = CW'(rect_left_i) + CW'(rect_width_i);
  assign bot_in   = CW'(rect_top_i) + CW'(rect_height_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q     <= CW'(rect_left_i);
      top_q      <= CW'(rect_top_i);
      right_q    <= right_in;
      bot_q      <= bot_in;
      left1_q    <= CW'(rect_left_i) + ONE;
      top1_q     <= CW'(rect_top_i) + ONE;
      right1_q   <= right_in - ONE;
      bot1_q     <= bot_in - ONE;
      filled_q   <= (shape_code_i == CHAR_FILLED);
      is_clear_q <= (command_i == CMD_CLEAR);
      ink_q      <= ink_char_i;
    end
  end

  assign px = signed'(CW'(col_q) << FRAC_BITS);
  assign py = signed'(CW'(row_q) << FRAC_BITS);

  assign in_rect  = (px >= left_q) && (px <= right_q) && (py >= top_q) && (py <= bot_q);
  assign edge_hit = (px < left1_q) || (px > right1_q) || (py < top1_q) || (py > bot1_q);
  assign paint    = is_clear_q || (in_rect && (filled_q || edge_hit));

  assign last_col = ((CNT_W'(col_q) + CNT_W'(1)) == w_used);
  assign last_row = ((CNT_W'(row_q) + CNT_W'(1)) == h_used);

  assign waddr = ADDR_W'(32'(row_q) * 32'(MAX_SIDE) + 32'(col_q));
  assign raddr = ADDR_W'(32'(pixel_row_i) * 32'(MAX_SIDE) + 32'(pixel_col_i));
  assign wdata = is_clear_q ? DATA_W'(bg_q) : ink_q;

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    done_d   = 1'b0;
    status_d = 1'b0;
    pix_d    = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_CLEAR: begin
              if (nonempty) begin
                state_d = ST_WALK;
              end else begin
                done_d = 1'b1;
              end
            end
            CMD_DRAW: begin
              if (!draw_ok) begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end else if (nonempty) begin
                state_d = ST_WALK;
              end else begin
                done_d = 1'b1;
              end
            end
            CMD_READ: begin
              if (rd_hit) begin
                mem_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        mem_we = paint;
        if (last_col) begin
          col_d = '0;
          if (last_row) begin
            row_d   = '0;
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end else begin
            row_d = row_q + IDX_W'(1);
          end
        end else begin
          col_d = col_q + IDX_W'(1);
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        pix_d   = rdata;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      col_q    <= '0;
      row_q    <= '0;
      done_q   <= 1'b0;
      status_q <= 1'b0;
      pix_q    <= '0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      done_q   <= done_d;
      status_q <= status_d;
      pix_q    <= pix_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign pixel_char_o = pix_q;

  rcr_canvas_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

@@ rtl/rcr_checker.sv @@
module rcr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 command_i,
  input logic [7:0]                 shape_code_i,
  input logic                       done_o,
  input logic                       status_o,
  input logic [rcr_pkg::DATA_W-1:0] pixel_char_o
);
  import rcr_pkg::*;

  a_quiet_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (!status_o && (pixel_char_o == '0)))
    else $error("Result fields are nonzero without a result strobe.");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("A long command ended without a result.");

  a_bad_shape_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == CMD_DRAW) &&
     (shape_code_i != CHAR_OUTLINE) && (shape_code_i != CHAR_FILLED))
    |=> (done_o && status_o && !busy))
    else $error("A draw with an unknown shape was not rejected at once.");

  a_status_only_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i != CMD_DRAW)) |=> !status_o)
    else $error("A command other than draw reported a rejection.");

  a_result_when_idle_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (pixel_char_o != '0)) |-> $past(busy))
    else $error("Pixel data appeared without a memory read cycle.");

endmodule

bind rect_canvas_rasterizer rcr_checker u_rcr_checker (.*);
